// ----- design/skvt_pkg.sv -----
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types, sizes and codes of the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

	// table geometry
	localparam int CAPACITY   = 64;
	localparam int KEY_BYTES  = 8;
	localparam int VALUE_BITS = 64;

	// fixed widths of the channel fields
	localparam int CMD_W         = 2;
	localparam int KEY_FIELD_W   = 64;
	localparam int VALUE_FIELD_W = 64;
	localparam int POS_W         = 6;
	localparam int CNT_FIELD_W   = 7;
	localparam int STATUS_W      = 2;

	// internal sizes
	localparam int KEY_W = KEY_BYTES * 8;
	localparam int VAL_W = VALUE_BITS;
	localparam int ENT_W = KEY_W + VAL_W;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE = 2'd0,
		STS_FULL = 2'd1,
		STS_MISS = 2'd2
	} status_t;

	// String-compare order: everything after the first NUL byte counts as NUL.
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_FIELD_W-1:0] raw);
		logic [KEY_W-1:0] k;
		logic             stop;
		k    = '0;
		stop = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[(KEY_BYTES-1-i)*8 +: 8] == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				k[(KEY_BYTES-1-i)*8 +: 8] = raw[(KEY_BYTES-1-i)*8 +: 8];
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- design/skvt_if.sv -----
// ----------------------------------------------------------------------------
// skvt_req_if / skvt_rsp_if
// Valid/ready channels for table commands and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface skvt_req_if;
	logic                               valid;
	logic                               ready;
	logic [skvt_pkg::CMD_W-1:0]         command;
	logic [skvt_pkg::KEY_FIELD_W-1:0]   key;
	logic [skvt_pkg::VALUE_FIELD_W-1:0] value;

	modport source (output valid, output command, output key, output value, input ready);
	modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface skvt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               found;
	logic [skvt_pkg::POS_W-1:0]         position;
	logic [skvt_pkg::VALUE_FIELD_W-1:0] value_out;
	logic [skvt_pkg::CNT_FIELD_W-1:0]   entry_count;
	logic [skvt_pkg::STATUS_W-1:0]      status;

	modport source (output valid, output found, output position, output value_out,
		output entry_count, output status, input ready);
	modport sink   (input valid, input found, input position, input value_out,
		input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ----- design/skvt_ram.sv -----
// ----------------------------------------------------------------------------
// skvt_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- design/sorted_key_value_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Sorted key/value table kept in one entry RAM, with lookup, insert and delete.
// ----------------------------------------------------------------------------
// Entries sit in ascending key order in a single RAM with one read and one
// write port. Each command on a non-empty table scans from entry 0, one entry
// per cycle, until it reaches a key not below the command's key or the last
// entry. An insert of a new key into a table that is not full then moves every
// later entry up by one and a delete hit moves them down, one entry per cycle
// through the RAM ports, and the insert then places the new entry. The slowest
// command is a new key inserted into a table one entry short of full: the scan
// and the move between them pass each entry once. The result waits in an
// output register, and a new command is taken while it waits. No clearing
// pass follows reset: only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	skvt_req_if.sink    req,
	skvt_rsp_if.source  rsp
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_SHIFT  = 6'b001000,
		ST_PLACE  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                             state_q;
	logic [skvt_pkg::CNT_W-1:0]         cnt_q;
	logic [skvt_pkg::CMD_W-1:0]         cmd_q;
	logic [skvt_pkg::KEY_W-1:0]         key_q;
	logic [skvt_pkg::VAL_W-1:0]         val_q;
	logic [skvt_pkg::VAL_W-1:0]         rval_q;
	logic [skvt_pkg::CNT_W-1:0]         pos_q;
	logic [skvt_pkg::IDX_W-1:0]         src_q;
	logic                               hit_q;
	logic                               full_q;
	logic                               up_q;

	logic                               o_valid_q;
	logic                               o_found_q;
	logic [skvt_pkg::POS_W-1:0]         o_pos_q;
	logic [skvt_pkg::VALUE_FIELD_W-1:0] o_val_q;
	logic [skvt_pkg::CNT_FIELD_W-1:0]   o_cnt_q;
	logic [skvt_pkg::STATUS_W-1:0]      o_status_q;

	logic                               we;
	logic [skvt_pkg::IDX_W-1:0]         waddr;
	logic [skvt_pkg::ENT_W-1:0]         wdata;
	logic [skvt_pkg::IDX_W-1:0]         raddr;
	logic [skvt_pkg::ENT_W-1:0]         rdata;
	logic [skvt_pkg::KEY_W-1:0]         rkey;
	logic [skvt_pkg::VAL_W-1:0]         rval;
	logic [skvt_pkg::CNT_W-1:0]         pos_inc;
	logic                               srch_more;
	logic                               shift_last;
	logic                               accept;
	logic                               out_free;
	logic                               is_lookup;

	skvt_ram #(
		.WIDTH (skvt_pkg::ENT_W),
		.DEPTH (skvt_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rkey      = rdata[skvt_pkg::VAL_W +: skvt_pkg::KEY_W];
	assign rval      = rdata[skvt_pkg::VAL_W-1:0];
	assign pos_inc   = pos_q + skvt_pkg::CNT_W'(1);
	assign srch_more = (rkey < key_q) && (pos_inc < cnt_q);
	assign shift_last = up_q ? (skvt_pkg::CNT_W'(src_q) == pos_q)
		: ((skvt_pkg::CNT_W'(src_q) + skvt_pkg::CNT_W'(1)) == cnt_q);
	assign accept    = req.valid && req.ready;
	assign out_free  = !o_valid_q || rsp.ready;
	assign is_lookup = (cmd_q != skvt_pkg::CMD_INSERT) && (cmd_q != skvt_pkg::CMD_DELETE);

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = o_valid_q;
	assign rsp.found       = o_found_q;
	assign rsp.position    = o_pos_q;
	assign rsp.value_out   = o_val_q;
	assign rsp.entry_count = o_cnt_q;
	assign rsp.status      = o_status_q;

	// RAM port steering. In a shift, read and write never hit the same entry in one cycle:
	// the shift reads the entry two places from the entry it writes.
	always_comb begin
		we    = 1'b0;
		waddr = skvt_pkg::IDX_W'(pos_q);
		wdata = {key_q, val_q};
		raddr = '0;
		case (state_q)
			ST_SEARCH: begin
				raddr = srch_more ? skvt_pkg::IDX_W'(pos_inc) : skvt_pkg::IDX_W'(pos_q);
			end
			ST_EXEC: begin
				we = (cmd_q == skvt_pkg::CMD_INSERT) && hit_q;
				if (cmd_q == skvt_pkg::CMD_INSERT) begin
					raddr = skvt_pkg::IDX_W'(cnt_q - skvt_pkg::CNT_W'(1));
				end else begin
					raddr = skvt_pkg::IDX_W'(pos_inc);
				end
			end
			ST_SHIFT: begin
				we    = 1'b1;
				wdata = rdata;
				if (up_q) begin
					waddr = src_q + skvt_pkg::IDX_W'(1);
					raddr = src_q - skvt_pkg::IDX_W'(1);
				end else begin
					waddr = src_q - skvt_pkg::IDX_W'(1);
					raddr = src_q + skvt_pkg::IDX_W'(1);
				end
			end
			ST_PLACE: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (cnt_q == '0) ? ST_EXEC : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (!srch_more) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if ((cmd_q == skvt_pkg::CMD_INSERT) && !hit_q
							&& (cnt_q != skvt_pkg::CNT_W'(skvt_pkg::CAPACITY))) begin
						state_q <= (pos_q < cnt_q) ? ST_SHIFT : ST_PLACE;
					end else if ((cmd_q == skvt_pkg::CMD_DELETE) && hit_q
							&& (pos_inc < cnt_q)) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_DONE;
						if ((cmd_q == skvt_pkg::CMD_DELETE) && hit_q) begin
							cnt_q <= cnt_q - skvt_pkg::CNT_W'(1);
						end
					end
				end
				ST_SHIFT: begin
					if (shift_last) begin
						if (up_q) begin
							state_q <= ST_PLACE;
						end else begin
							state_q <= ST_DONE;
							cnt_q   <= cnt_q - skvt_pkg::CNT_W'(1);
						end
					end
				end
				ST_PLACE: begin
					state_q <= ST_DONE;
					cnt_q   <= cnt_q + skvt_pkg::CNT_W'(1);
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q  <= req.command;
					key_q  <= skvt_pkg::norm_key(req.key);
					val_q  <= req.value[skvt_pkg::VAL_W-1:0];
					pos_q  <= '0;
					hit_q  <= 1'b0;
					full_q <= 1'b0;
				end
			end
			ST_SEARCH: begin
				if (srch_more || (rkey < key_q)) begin
					pos_q <= pos_inc;
				end
				if (!srch_more) begin
					hit_q  <= (rkey == key_q);
					rval_q <= rval;
				end
			end
			ST_EXEC: begin
				if (cmd_q == skvt_pkg::CMD_INSERT) begin
					full_q <= !hit_q && (cnt_q == skvt_pkg::CNT_W'(skvt_pkg::CAPACITY));
					up_q   <= 1'b1;
					src_q  <= skvt_pkg::IDX_W'(cnt_q - skvt_pkg::CNT_W'(1));
				end else begin
					up_q  <= 1'b0;
					src_q <= skvt_pkg::IDX_W'(pos_inc);
				end
			end
			ST_SHIFT: begin
				src_q <= up_q ? (src_q - skvt_pkg::IDX_W'(1)) : (src_q + skvt_pkg::IDX_W'(1));
			end
			ST_DONE: begin
				if (out_free) begin
					o_found_q <= hit_q;
					o_pos_q   <= skvt_pkg::POS_W'(pos_q);
					o_val_q   <= (is_lookup && hit_q) ?
						skvt_pkg::VALUE_FIELD_W'(rval_q) : '0;
					o_cnt_q   <= skvt_pkg::CNT_FIELD_W'(cnt_q);
					if (full_q) begin
						o_status_q <= skvt_pkg::STS_FULL;
					end else if (!hit_q && (cmd_q != skvt_pkg::CMD_INSERT)) begin
						o_status_q <= skvt_pkg::STS_MISS;
					end else begin
						o_status_q <= skvt_pkg::STS_DONE;
					end
				end
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/skvt_checker.sv -----
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks on the result channel of the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_ready,
	input wire logic                               found,
	input wire logic [skvt_pkg::POS_W-1:0]         position,
	input wire logic [skvt_pkg::VALUE_FIELD_W-1:0] value_out,
	input wire logic [skvt_pkg::CNT_FIELD_W-1:0]   entry_count,
	input wire logic [skvt_pkg::STATUS_W-1:0]      status
);

	logic [skvt_pkg::CNT_FIELD_W-1:0] last_cnt_q;

	// entry count reported by the previous result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			last_cnt_q <= entry_count;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({found, position, value_out, entry_count, status}))
		else $error("result beat changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == skvt_pkg::STS_FULL) |->
			!found && (entry_count == skvt_pkg::CNT_FIELD_W'(skvt_pkg::CAPACITY)))
		else $error("full status with table not full");

	a_value_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (value_out != '0) |-> found && (status == skvt_pkg::STS_DONE))
		else $error("nonzero value on a miss");

	// a new key adds one entry, a delete hit removes one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |->
			(entry_count == last_cnt_q)
			|| (!found && (entry_count == last_cnt_q + skvt_pkg::CNT_FIELD_W'(1)))
			|| (found && (entry_count == last_cnt_q - skvt_pkg::CNT_FIELD_W'(1))))
		else $error("entry count jumped");

endmodule

bind sorted_key_value_table_core skvt_checker u_skvt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.found       (rsp.found),
	.position    (rsp.position),
	.value_out   (rsp.value_out),
	.entry_count (rsp.entry_count),
	.status      (rsp.status)
);

`default_nettype wire
